### hw/rtl/cpu_control_register_and_branch_unit_defines.svh
// Assertion macros for the control register and branch unit.
// Included by the files that carry concurrent assertions; needs clk and rst in scope.
`ifndef CPU_CONTROL_REGISTER_AND_BRANCH_UNIT_DEFINES_SVH
`define CPU_CONTROL_REGISTER_AND_BRANCH_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define CRBU_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crbu assertion failed");
// next-cycle implication
`define CRBU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crbu assertion failed");
`else
`define CRBU_ASSERT(label, ante, cons)
`define CRBU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/crbu_pkg.sv
// Shared types and constants of the control register and branch unit.
// No dependencies; used by the interfaces' users, crbu_exec and the top level.
package crbu_pkg;

  localparam int NUM_LEVELS = 4;  // exception levels with a bank, 2..4
  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam logic [1:0] LEVEL_MAX = 2'(NUM_LEVELS - 1);

  localparam logic [7:0] PSW_C_MASK = 8'h80;
  localparam int PSW_C_BIT  = 7;
  localparam int PSW_Z_BIT  = 6;
  localparam int PSW_S_BIT  = 5;
  localparam int PSW_OV_BIT = 4;

  typedef enum logic [4:0] {
    MODE_ADDSP    = 5'd0,
    MODE_WR_ECSR  = 5'd1,
    MODE_WR_ELR   = 5'd2,
    MODE_WR_EPSW  = 5'd3,
    MODE_RD_ELR   = 5'd4,
    MODE_RD_SP    = 5'd5,
    MODE_WR_PSW   = 5'd6,
    MODE_RD_ECSR  = 5'd7,
    MODE_RD_EPSW  = 5'd8,
    MODE_RD_PSW   = 5'd9,
    MODE_WR_SP    = 5'd10,
    MODE_LEA      = 5'd11,
    MODE_PSW_OR   = 5'd12,
    MODE_PSW_AND  = 5'd13,
    MODE_CPLC     = 5'd14,
    MODE_BC       = 5'd15,
    MODE_B        = 5'd16,
    MODE_BL       = 5'd17,
    MODE_RT       = 5'd18,
    MODE_RTI      = 5'd19
  } mode_t;

  typedef enum logic [3:0] {
    COND_NC     = 4'd0,
    COND_C      = 4'd1,
    COND_GT     = 4'd2,
    COND_LE     = 4'd3,
    COND_GE     = 4'd4,
    COND_LT     = 4'd5,
    COND_GTS    = 4'd6,
    COND_LES    = 4'd7,
    COND_NZ     = 4'd8,
    COND_Z      = 4'd9,
    COND_NOV    = 4'd10,
    COND_OV     = 4'd11,
    COND_NS     = 4'd12,
    COND_S      = 4'd13,
    COND_AL     = 4'd14,
    COND_AL_ALT = 4'd15
  } cond_t;

  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] operand_value;
    logic [15:0] long_immediate;
    logic        has_long_immediate;
    logic        has_register;
    logic [3:0]  branch_condition;
    logic [7:0]  psw_immediate;
    logic [7:0]  flags_in;
    logic [15:0] current_pc;
  } instr_t;

  typedef struct packed {
    logic [7:0]  psw;
    logic [15:0] sp;
    logic [15:0] ea;
    logic [15:0] link_pc;
    logic [7:0]  link_segment;
    logic [7:0]  segment;
  } arch_t;

  typedef struct packed {
    logic [7:0]  seg;
    logic [15:0] pc;
    logic [7:0]  psw;
  } bank_entry_t;

  typedef struct packed {
    logic        seg_we;
    logic        pc_we;
    logic        psw_we;
    bank_entry_t data;
  } bank_wr_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [15:0] next_pc;
    logic        branch_taken;
  } exec_out_t;

endpackage

### hw/rtl/crbu_if.sv
// Valid/ready channel interfaces of the control register and branch unit.
// Instruction channel and result channel; no dependencies.
interface crbu_instr_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic [15:0] operand_value;
  logic [15:0] long_immediate;
  logic        has_long_immediate;
  logic        has_register;
  logic [3:0]  branch_condition;
  logic [7:0]  psw_immediate;
  logic [7:0]  flags_in;
  logic [15:0] current_pc;

  modport source (
    output valid, mode, operand_value, long_immediate, has_long_immediate,
           has_register, branch_condition, psw_immediate, flags_in, current_pc,
    input  ready
  );
  modport sink (
    input  valid, mode, operand_value, long_immediate, has_long_immediate,
           has_register, branch_condition, psw_immediate, flags_in, current_pc,
    output ready
  );
endinterface

interface crbu_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic [15:0] next_pc;
  logic [7:0]  code_segment;
  logic [7:0]  status_word;
  logic [15:0] stack_pointer;
  logic [15:0] effective_address;
  logic        branch_taken;

  modport source (
    output valid, read_value, next_pc, code_segment, status_word, stack_pointer,
           effective_address, branch_taken,
    input  ready
  );
  modport sink (
    input  valid, read_value, next_pc, code_segment, status_word, stack_pointer,
           effective_address, branch_taken,
    output ready
  );
endinterface

### hw/rtl/crbu_exec.sv
// Single-pass execute logic: next architectural state, bank write and result.
// Depends on crbu_pkg.
module crbu_exec import crbu_pkg::*; (
  input  instr_t      item,
  input  arch_t       cur,
  input  bank_entry_t bank_rd,
  input  logic        sp_align,
  output arch_t       nxt,
  output bank_wr_t    bank_wr,
  output exec_out_t   res
);

  logic        f_c, f_z, f_s, f_ov;
  logic        le, lts, les;
  logic        cond_ok;
  logic [15:0] disp8;
  logic [15:0] sp_sum;
  logic [15:0] lea_sum;
  logic [15:0] bc_target;
  logic        level_nonzero;

  assign f_c  = item.flags_in[PSW_C_BIT];
  assign f_z  = item.flags_in[PSW_Z_BIT];
  assign f_s  = item.flags_in[PSW_S_BIT];
  assign f_ov = item.flags_in[PSW_OV_BIT];
  assign le   = f_z | f_c;
  assign lts  = f_ov ^ f_s;
  assign les  = lts | f_z;

  always_comb begin
    case (cond_t'(item.branch_condition))
      COND_NC:     cond_ok = !f_c;
      COND_C:      cond_ok = f_c;
      COND_GT:     cond_ok = !le;
      COND_LE:     cond_ok = le;
      COND_GE:     cond_ok = !lts;
      COND_LT:     cond_ok = lts;
      COND_GTS:    cond_ok = !les;
      COND_LES:    cond_ok = les;
      COND_NZ:     cond_ok = !f_z;
      COND_Z:      cond_ok = f_z;
      COND_NOV:    cond_ok = !f_ov;
      COND_OV:     cond_ok = f_ov;
      COND_NS:     cond_ok = !f_s;
      COND_S:      cond_ok = f_s;
      COND_AL,
      COND_AL_ALT: cond_ok = 1'b1;
      default:     cond_ok = 1'b1;
    endcase
  end

  assign disp8         = {{8{item.operand_value[7]}}, item.operand_value[7:0]};
  assign sp_sum        = cur.sp + disp8;
  assign lea_sum       = (item.has_register ? item.operand_value : 16'h0000)
                       + (item.has_long_immediate ? item.long_immediate : 16'h0000);
  // halfword displacement
  assign bc_target     = item.current_pc + {disp8[14:0], 1'b0};
  assign level_nonzero = |cur.psw[1:0];

  always_comb begin
    nxt                  = cur;
    bank_wr              = '0;
    bank_wr.data.seg     = item.operand_value[7:0];
    bank_wr.data.pc      = item.operand_value;
    bank_wr.data.psw     = item.operand_value[7:0];
    res.read_value       = 16'h0000;
    res.next_pc          = item.current_pc;
    res.branch_taken     = 1'b0;

    case (mode_t'(item.mode))
      MODE_ADDSP: begin
        nxt.sp = {sp_sum[15:1], sp_sum[0] & !sp_align};
      end
      MODE_WR_ECSR: bank_wr.seg_we = 1'b1;
      MODE_WR_ELR:  bank_wr.pc_we  = 1'b1;
      MODE_WR_EPSW: bank_wr.psw_we = level_nonzero;
      MODE_RD_ELR:  res.read_value = bank_rd.pc;
      MODE_RD_SP:   res.read_value = cur.sp;
      MODE_WR_PSW:  nxt.psw = item.operand_value[7:0];
      MODE_RD_ECSR: res.read_value = {8'h00, bank_rd.seg};
      MODE_RD_EPSW: begin
        if (level_nonzero) begin
          res.read_value = {8'h00, bank_rd.psw};
        end
      end
      MODE_RD_PSW:  res.read_value = {8'h00, cur.psw};
      MODE_WR_SP: begin
        nxt.sp = {item.operand_value[15:1], item.operand_value[0] & !sp_align};
      end
      MODE_LEA:     nxt.ea  = lea_sum;
      MODE_PSW_OR:  nxt.psw = cur.psw | item.psw_immediate;
      MODE_PSW_AND: nxt.psw = cur.psw & item.psw_immediate;
      MODE_CPLC:    nxt.psw = cur.psw ^ PSW_C_MASK;
      MODE_BC: begin
        if (cond_ok) begin
          res.next_pc      = bc_target;
          res.branch_taken = 1'b1;
        end
      end
      MODE_B, MODE_BL: begin
        if (mode_t'(item.mode) == MODE_BL) begin
          nxt.link_pc      = item.current_pc;
          nxt.link_segment = cur.segment;
        end
        if (item.has_long_immediate) begin
          nxt.segment = item.operand_value[7:0];
          res.next_pc = item.long_immediate;
        end else begin
          res.next_pc = item.operand_value;
        end
        res.branch_taken = 1'b1;
      end
      MODE_RT: begin
        nxt.segment      = cur.link_segment;
        res.next_pc      = cur.link_pc;
        res.branch_taken = 1'b1;
      end
      MODE_RTI: begin
        nxt.segment      = bank_rd.seg;
        nxt.psw          = bank_rd.psw;
        res.next_pc      = bank_rd.pc;
        res.branch_taken = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/cpu_control_register_and_branch_unit.sv
// Top level of the control register and branch unit: pipeline, state and banks.
// Depends on crbu_pkg, crbu_if.sv, crbu_exec and the assertion macro header.
//
// Executes one decoded control-flow or control-register instruction per
// transfer and returns one result per instruction, in order. It holds PSW,
// SP, EA, the link pc/segment, the code segment and one bank of saved
// segment, pc and PSW per exception level (NUM_LEVELS in crbu_pkg, 2..4);
// the bank used is PSW bits 1:0, saturated to the top level present.
// Throughput is one instruction per clock while the result side keeps up:
// an instruction lands in an input register, crosses the execute logic in
// one pass while the state updates, and its result is held in an output
// register, which offers it to the result side. The result register lets a
// new instruction enter while an earlier result is still waiting, and
// back-pressure from the result side reaches the instruction side through
// the input register only when both are full. cfg_wr_en/cfg_wr_data set
// sp_align (clear SP bit 0 after SP writes and adds); write it only while the unit is
// empty. Reset is synchronous and clears all state, banks included.
`include "cpu_control_register_and_branch_unit_defines.svh"

module cpu_control_register_and_branch_unit import crbu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  crbu_instr_if.sink    instr,
  crbu_result_if.source result,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);

  // input stage
  logic   s1_valid;
  instr_t s1_instr;
  logic   advance;

  // architectural state
  arch_t       arch;
  arch_t       arch_next;
  logic        sp_align;
  bank_entry_t banks [NUM_LEVELS];
  logic [1:0]  lvl_sat;
  logic [LVL_W-1:0] lvl;
  bank_wr_t    bank_wr;
  exec_out_t   exec_res;

  // result stage
  logic        out_valid;
  logic [15:0] out_read_value;
  logic [15:0] out_next_pc;
  logic [7:0]  out_code_segment;
  logic [7:0]  out_status_word;
  logic [15:0] out_stack_pointer;
  logic [15:0] out_effective_address;
  logic        out_branch_taken;

  // The input stage moves on whenever the result register is free or drains.
  assign advance     = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_instr.mode               <= instr.mode;
      s1_instr.operand_value      <= instr.operand_value;
      s1_instr.long_immediate     <= instr.long_immediate;
      s1_instr.has_long_immediate <= instr.has_long_immediate;
      s1_instr.has_register       <= instr.has_register;
      s1_instr.branch_condition   <= instr.branch_condition;
      s1_instr.psw_immediate      <= instr.psw_immediate;
      s1_instr.flags_in           <= instr.flags_in;
      s1_instr.current_pc         <= instr.current_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_align <= 1'b0;
    end else if (cfg_wr_en) begin
      sp_align <= cfg_wr_data;
    end
  end

  // Bank index: exception level from PSW, clipped to the levels present.
  assign lvl_sat = (arch.psw[1:0] > LEVEL_MAX) ? LEVEL_MAX : arch.psw[1:0];
  assign lvl     = lvl_sat[LVL_W-1:0];

  crbu_exec u_exec (
    .item     (s1_instr),
    .cur      (arch),
    .bank_rd  (banks[lvl]),
    .sp_align (sp_align),
    .nxt      (arch_next),
    .bank_wr  (bank_wr),
    .res      (exec_res)
  );

  // State commits exactly once per instruction, as it enters the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '0;
    end else if (advance) begin
      arch <= arch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        banks[i] <= '0;
      end
    end else if (advance) begin
      if (bank_wr.seg_we) begin
        banks[lvl].seg <= bank_wr.data.seg;
      end
      if (bank_wr.pc_we) begin
        banks[lvl].pc <= bank_wr.data.pc;
      end
      if (bank_wr.psw_we) begin
        banks[lvl].psw <= bank_wr.data.psw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_value        <= exec_res.read_value;
      out_next_pc           <= exec_res.next_pc;
      out_branch_taken      <= exec_res.branch_taken;
      out_code_segment      <= arch_next.segment;
      out_status_word       <= arch_next.psw;
      out_stack_pointer     <= arch_next.sp;
      out_effective_address <= arch_next.ea;
    end
  end

  assign result.valid             = out_valid;
  assign result.read_value        = out_read_value;
  assign result.next_pc           = out_next_pc;
  assign result.code_segment      = out_code_segment;
  assign result.status_word       = out_status_word;
  assign result.stack_pointer     = out_stack_pointer;
  assign result.effective_address = out_effective_address;
  assign result.branch_taken      = out_branch_taken;

  // a stalled instruction stays in the input stage
  `CRBU_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid)
  // state only moves with an instruction
  `CRBU_ASSERT_NEXT(a_arch_frozen, !advance, $stable(arch))
  // reported PSW/SP match the committed registers
  `CRBU_ASSERT_NEXT(a_state_reported, advance,
                    result.status_word == arch.psw && result.stack_pointer == arch.sp)
  // untaken instructions fall through to the fetched pc
  `CRBU_ASSERT_NEXT(a_fall_through, advance && !exec_res.branch_taken,
                    result.next_pc == $past(s1_instr.current_pc))

endmodule

### sim/cpu_control_register_and_branch_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for cpu_control_register_and_branch_unit.
// Needs crbu_pkg, crbu_if.sv and the RTL; predicts every result and checks it in order.

module cpu_control_register_and_branch_unit_tb;
  import crbu_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Wait that lets the input register and the result register empty.
  localparam int DRAIN_CYCLES = 3;
  localparam int MAX_REPORTS = 10;

  // One result as the unit presents it on the result channel.
  typedef struct packed {
    logic [15:0] read_value;
    logic [15:0] next_pc;
    logic [7:0]  code_segment;
    logic [7:0]  status_word;
    logic [15:0] stack_pointer;
    logic [15:0] effective_address;
    logic        branch_taken;
  } crbu_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  crbu_instr_if  instr_ch ();
  crbu_result_if result_ch ();

  cpu_control_register_and_branch_unit dut (
    .clk         (clk),
    .rst         (rst),
    .instr       (instr_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Shadow copy of the architectural state, updated at each instruction transfer.
  logic [7:0]  psw_q;
  logic [15:0] sp_q;
  logic [15:0] ea_q;
  logic [15:0] link_pc_q;
  logic [7:0]  link_seg_q;
  logic [7:0]  seg_q;
  logic        sp_align_q;
  logic [7:0]  bank_seg_q [4];
  logic [15:0] bank_pc_q  [4];
  logic [7:0]  bank_psw_q [4];

  // Results predicted but not yet seen, oldest first.
  crbu_result_t pending_results[$];

  int mismatch_count;
  int snd_idle_pct;   // chance in 100 that the sender inserts an idle cycle
  int rcv_idle_pct;   // chance in 100 that the receiver drops ready
  int hold_req;       // long receiver hold-off, picked up by the checker process

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] sext8(logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  // Condition codes of the conditional branch, flags in PSW layout.
  function automatic logic cond_holds(logic [3:0] cc, logic [7:0] f);
    logic c, z, s, ov, le, lts, les;
    c   = f[PSW_C_BIT];
    z   = f[PSW_Z_BIT];
    s   = f[PSW_S_BIT];
    ov  = f[PSW_OV_BIT];
    le  = z | c;
    lts = ov ^ s;
    les = lts | z;
    case (cc)
      COND_NC:  return !c;
      COND_C:   return c;
      COND_GT:  return !le;
      COND_LE:  return le;
      COND_GE:  return !lts;
      COND_LT:  return lts;
      COND_GTS: return !les;
      COND_LES: return les;
      COND_NZ:  return !z;
      COND_Z:   return z;
      COND_NOV: return !ov;
      COND_OV:  return ov;
      COND_NS:  return !s;
      COND_S:   return s;
      default:  return 1'b1;  // both "always" codes
    endcase
  endfunction

  function void clear_arch_state();
    psw_q      = '0;
    sp_q       = '0;
    ea_q       = '0;
    link_pc_q  = '0;
    link_seg_q = '0;
    seg_q      = '0;
    sp_align_q = 1'b0;
    for (int i = 0; i < 4; i++) begin
      bank_seg_q[i] = '0;
      bank_pc_q[i]  = '0;
      bank_psw_q[i] = '0;
    end
  endfunction

  // Applies one instruction to the shadow state and returns the result it produces.
  function crbu_result_t execute_instr(instr_t it);
    crbu_result_t r;
    logic [1:0]   lvl;
    logic [15:0]  disp;
    // bank index: PSW level, saturated to the top level present
    lvl = (psw_q[1:0] > LEVEL_MAX) ? LEVEL_MAX : psw_q[1:0];
    r.read_value   = '0;
    r.next_pc      = it.current_pc;
    r.branch_taken = 1'b0;
    case (it.mode)
      MODE_ADDSP: begin
        sp_q = sp_q + sext8(it.operand_value[7:0]);
        if (sp_align_q) sp_q[0] = 1'b0;
      end
      MODE_WR_ECSR: bank_seg_q[lvl] = it.operand_value[7:0];
      MODE_WR_ELR:  bank_pc_q[lvl]  = it.operand_value;
      MODE_WR_EPSW: begin
        // no saved PSW at level zero
        if (psw_q[1:0] != 2'd0) bank_psw_q[lvl] = it.operand_value[7:0];
      end
      MODE_RD_ELR:  r.read_value = bank_pc_q[lvl];
      MODE_RD_SP:   r.read_value = sp_q;
      MODE_WR_PSW:  psw_q = it.operand_value[7:0];
      MODE_RD_ECSR: r.read_value = {8'h00, bank_seg_q[lvl]};
      MODE_RD_EPSW: begin
        if (psw_q[1:0] != 2'd0) r.read_value = {8'h00, bank_psw_q[lvl]};
      end
      MODE_RD_PSW:  r.read_value = {8'h00, psw_q};
      MODE_WR_SP: begin
        sp_q = it.operand_value;
        if (sp_align_q) sp_q[0] = 1'b0;
      end
      MODE_LEA: begin
        ea_q = (it.has_register ? it.operand_value : 16'h0000) +
               (it.has_long_immediate ? it.long_immediate : 16'h0000);
      end
      MODE_PSW_OR:  psw_q = psw_q | it.psw_immediate;
      MODE_PSW_AND: psw_q = psw_q & it.psw_immediate;
      MODE_CPLC:    psw_q = psw_q ^ PSW_C_MASK;
      MODE_BC: begin
        if (cond_holds(it.branch_condition, it.flags_in)) begin
          disp = sext8(it.operand_value[7:0]);
          r.next_pc = it.current_pc + {disp[14:0], 1'b0};
          r.branch_taken = 1'b1;
        end
      end
      MODE_B, MODE_BL: begin
        if (it.mode == MODE_BL) begin
          link_pc_q  = it.current_pc;
          link_seg_q = seg_q;
        end
        if (it.has_long_immediate) begin
          seg_q     = it.operand_value[7:0];
          r.next_pc = it.long_immediate;
        end else begin
          r.next_pc = it.operand_value;
        end
        r.branch_taken = 1'b1;
      end
      MODE_RT: begin
        seg_q = link_seg_q;
        r.next_pc = link_pc_q;
        r.branch_taken = 1'b1;
      end
      MODE_RTI: begin
        seg_q = bank_seg_q[lvl];
        r.next_pc = bank_pc_q[lvl];
        psw_q = bank_psw_q[lvl];
        r.branch_taken = 1'b1;
      end
      default: ;  // unused modes change nothing
    endcase
    r.code_segment      = seg_q;
    r.status_word       = psw_q;
    r.stack_pointer     = sp_q;
    r.effective_address = ea_q;
    return r;
  endfunction

  // Words biased toward the edges of the 16-bit and signed 8-bit ranges.
  function automatic logic [15:0] rand_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h007F;
      3:       return 16'h0080;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    // a few unused modes so the upper mode bits get exercised
    it.mode = ($urandom_range(99) < 6) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19));
    it.operand_value      = rand_word();
    it.long_immediate     = rand_word();
    it.has_long_immediate = 1'($urandom_range(1));
    it.has_register       = 1'($urandom_range(1));
    it.branch_condition   = 4'($urandom_range(15));
    it.psw_immediate      = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom());
    it.flags_in           = 8'($urandom());
    it.current_pc         = rand_word();
    return it;
  endfunction

  function automatic instr_t instr_with(logic [4:0] mode, logic [15:0] opv);
    instr_t it;
    it = random_instr();
    it.mode = mode;
    it.operand_value = opv;
    return it;
  endfunction

  // Offer one instruction, hold it until the transfer, then predict its result.
  // valid stays high after the transfer; a drain lowers it, and the next call lowers it only to insert an idle gap.
  task automatic send_instr(input instr_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_ch.valid              <= 1'b1;
    instr_ch.mode               <= it.mode;
    instr_ch.operand_value      <= it.operand_value;
    instr_ch.long_immediate     <= it.long_immediate;
    instr_ch.has_long_immediate <= it.has_long_immediate;
    instr_ch.has_register       <= it.has_register;
    instr_ch.branch_condition   <= it.branch_condition;
    instr_ch.psw_immediate      <= it.psw_immediate;
    instr_ch.flags_in           <= it.flags_in;
    instr_ch.current_pc         <= it.current_pc;
    do @(posedge clk); while (instr_ch.ready !== 1'b1);
    pending_results.insert(pending_results.size(), execute_instr(it));
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic wait_drain();
    instr_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // sp_align is only written with the unit empty.
  task automatic write_sp_align(input logic v);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sp_align_q = v;
  endtask

  // Every mode once or more, field extremes, and the level-zero and wrap cases.
  task automatic test_directed_ops();
    instr_t it;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // level zero: EPSW write is dropped and EPSW reads as zero
    send_instr(instr_with(MODE_RD_PSW, 16'h0000));
    send_instr(instr_with(MODE_WR_EPSW, 16'hABCD));
    send_instr(instr_with(MODE_RD_EPSW, 16'hFFFF));
    // bank writes keep only the low byte where the bank is 8 bits
    send_instr(instr_with(MODE_WR_ECSR, 16'h12FE));
    send_instr(instr_with(MODE_WR_ELR, 16'hFFFF));
    send_instr(instr_with(MODE_RD_ECSR, 16'h0000));
    send_instr(instr_with(MODE_RD_ELR, 16'h0000));
    // return from level zero uses the level-zero entries as they are
    send_instr(instr_with(MODE_RTI, 16'h0000));
    // SP wraps up and down
    send_instr(instr_with(MODE_WR_SP, 16'hFFFF));
    send_instr(instr_with(MODE_ADDSP, 16'hFF01));
    send_instr(instr_with(MODE_ADDSP, 16'h0080));
    send_instr(instr_with(MODE_RD_SP, 16'h0000));
    // top level, upper PSW byte of the operand ignored
    send_instr(instr_with(MODE_WR_PSW, 16'hFF03));
    send_instr(instr_with(MODE_WR_EPSW, 16'h00F2));
    send_instr(instr_with(MODE_RD_EPSW, 16'h0000));
    it = instr_with(MODE_PSW_OR, 16'h0000);
    it.psw_immediate = 8'hF0;
    send_instr(it);
    it = instr_with(MODE_PSW_AND, 16'h0000);
    it.psw_immediate = 8'h7F;
    send_instr(it);
    send_instr(instr_with(MODE_CPLC, 16'h0000));
    // lea with both parts, sum wraps
    it = instr_with(MODE_LEA, 16'hFFFF);
    it.has_register = 1'b1;
    it.has_long_immediate = 1'b1;
    it.long_immediate = 16'h0002;
    send_instr(it);
    // most negative displacement wraps below zero
    it = instr_with(MODE_BC, 16'h0080);
    it.branch_condition = COND_AL;
    it.current_pc = 16'h0010;
    send_instr(it);
    it = instr_with(MODE_BC, 16'h007F);
    it.branch_condition = COND_C;
    it.flags_in = 8'h00;
    send_instr(it);
    // far call, return, near branch
    it = instr_with(MODE_BL, 16'h00A5);
    it.has_long_immediate = 1'b1;
    it.long_immediate = 16'hFFFE;
    send_instr(it);
    send_instr(instr_with(MODE_RT, 16'h0000));
    it = instr_with(MODE_B, 16'h8000);
    it.has_long_immediate = 1'b0;
    send_instr(it);
    send_instr(instr_with(5'd31, 16'hFFFF));
    send_instr(instr_with(MODE_RTI, 16'h0000));
  endtask

  // With sp_align set, SP bit 0 clears after a move and after an add.
  task automatic test_sp_alignment();
    send_instr(instr_with(MODE_WR_SP, 16'hFFFF));
    send_instr(instr_with(MODE_ADDSP, 16'h0003));
    send_instr(instr_with(MODE_RD_SP, 16'h0000));
  endtask

  // Random traffic: mostly single instructions, plus exception round trips
  // and call/return pairs with random content.
  task automatic test_random_traffic(input int snd, input int rcv, input int n_items);
    int     sent;
    instr_t it;
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          // enter a level, fill its bank, do something, return
          send_instr(instr_with(MODE_WR_PSW, rand_word()));
          send_instr(instr_with(MODE_WR_ECSR, rand_word()));
          send_instr(instr_with(MODE_WR_ELR, rand_word()));
          send_instr(instr_with(MODE_WR_EPSW, rand_word()));
          send_instr(random_instr());
          send_instr(instr_with(MODE_RTI, rand_word()));
          sent += 6;
        end
        1: begin
          send_instr(instr_with(MODE_BL, rand_word()));
          send_instr(random_instr());
          send_instr(instr_with(MODE_RT, rand_word()));
          sent += 3;
        end
        default: begin
          it = random_instr();
          send_instr(it);
          sent++;
        end
      endcase
    end
  endtask

  // Receiver holds off long enough for both registers to fill and stall the
  // instruction side; then the sender pauses until everything has drained.
  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 60;
    repeat (24) send_instr(random_instr());
    wait_drain();
  endtask

  // Result side: check each transfer against the oldest prediction, then pick
  // ready for the next cycle. Values are sampled as they stood before the edge.
  initial begin
    crbu_result_t got;
    crbu_result_t want;
    int           hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        got.read_value        = result_ch.read_value;
        got.next_pc           = result_ch.next_pc;
        got.code_segment      = result_ch.code_segment;
        got.status_word       = result_ch.status_word;
        got.stack_pointer     = result_ch.stack_pointer;
        got.effective_address = result_ch.effective_address;
        got.branch_taken      = result_ch.branch_taken;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result rd=%h pc=%h cs=%h psw=%h sp=%h ea=%h bt=%b",
                     $realtime, got.read_value, got.next_pc, got.code_segment,
                     got.status_word, got.stack_pointer, got.effective_address,
                     got.branch_taken);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: mismatch exp rd=%h pc=%h cs=%h psw=%h sp=%h ea=%h bt=%b",
                       $realtime, want.read_value, want.next_pc, want.code_segment,
                       want.status_word, want.stack_pointer, want.effective_address,
                       want.branch_taken);
              $display("%0t:          got rd=%h pc=%h cs=%h psw=%h sp=%h ea=%h bt=%b",
                       $realtime, got.read_value, got.next_pc, got.code_segment,
                       got.status_word, got.stack_pointer, got.effective_address,
                       got.branch_taken);
            end
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("cpu_control_register_and_branch_unit test failed");
    $finish;
  end

  // Test sequence
  initial begin
    rst                         <= 1'b1;
    cfg_wr_en                   <= 1'b0;
    cfg_wr_data                 <= 1'b0;
    instr_ch.valid              <= 1'b0;
    instr_ch.mode               <= '0;
    instr_ch.operand_value      <= '0;
    instr_ch.long_immediate     <= '0;
    instr_ch.has_long_immediate <= 1'b0;
    instr_ch.has_register       <= 1'b0;
    instr_ch.branch_condition   <= '0;
    instr_ch.psw_immediate      <= '0;
    instr_ch.flags_in           <= '0;
    instr_ch.current_pc         <= '0;
    result_ch.ready             <= 1'b0;
    snd_idle_pct   = 0;
    rcv_idle_pct   = 0;
    hold_req       = 0;
    mismatch_count = 0;
    clear_arch_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_sp_align(1'b0);
    test_directed_ops();
    write_sp_align(1'b1);
    test_sp_alignment();
    // sender idles lightly, receiver heavily
    test_random_traffic(32, 86, 520);
    write_sp_align(1'b0);
    // and the other way round
    test_random_traffic(86, 32, 520);
    write_sp_align(1'b1);
    test_backpressure();
    // no idling at all
    test_random_traffic(0, 0, 520);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("cpu_control_register_and_branch_unit test passed");
    end else begin
      $display("cpu_control_register_and_branch_unit test failed");
    end
    $finish;
  end

endmodule
